FILE: design/marker_framed_word_receiver_defines.svh
// ---------------------------------------------------------------------------
// marker framed word receiver assertion macros
// concurrent checks on clock, disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef MARKER_FRAMED_WORD_RECEIVER_DEFINES_SVH
`define MARKER_FRAMED_WORD_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

`define MFWR_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mfwr check failed");

`define MFWR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mfwr check failed");

`else

`define MFWR_ASSERT_IMPLY(label, ante, cons)

`define MFWR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/mfwr_pkg.sv
// ---------------------------------------------------------------------------
// mfwr_pkg
// shared types and constants of the marker framed word receiver
// ---------------------------------------------------------------------------
package mfwr_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 32;
   localparam int POS_W       = 6;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int PHASE_W     = 2;

   localparam logic [BYTE_W-1:0] RECORD_SIZE        = 8'd4;
   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd3;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MARKER   = 1'b1;

   typedef struct packed {
      logic clear_count;
      logic start_record;
      logic take_byte;
      logic store_word;
      logic drain_start;
      logic drain_read;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_start;
      logic is_end;
      logic is_size;
      logic last_byte;
      logic count_last;
      logic out_last;
   } ctl_sts_type;

endpackage

FILE: design/mfwr_channels.sv
// ---------------------------------------------------------------------------
// mfwr channel interfaces
// valid/ready channels for received bytes and emitted words
// ---------------------------------------------------------------------------
interface mfwr_req_if;
   import mfwr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfwr_rsp_if;
   import mfwr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] word_value;
   logic [POS_W-1:0]         word_position;
   logic                     last_of_frame;

   modport source (output valid, output word_value, output word_position,
                   output last_of_frame, input ready);
   modport sink   (input valid, input word_value, input word_position,
                   input last_of_frame, output ready);
endinterface

FILE: design/mfwr_datapath.sv
// ---------------------------------------------------------------------------
// mfwr_datapath
// marker registers, word assembly, value store and output registers
// ---------------------------------------------------------------------------
module mfwr_datapath #(
   parameter int FRAME_WORDS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mfwr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mfwr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [mfwr_pkg::BYTE_W-1:0]       rx_byte,
   input  mfwr_pkg::ctl_cmd_type             cmd,
   output mfwr_pkg::ctl_sts_type             sts,
   output logic signed [mfwr_pkg::WORD_W-1:0] word_value,
   output logic [mfwr_pkg::POS_W-1:0]        word_position,
   output logic                              last_of_frame
);
   import mfwr_pkg::*;

   localparam int IDX_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_WORDS - 1);

   logic [BYTE_W-1:0] start_marker_ff;
   logic [BYTE_W-1:0] end_marker_ff;
   logic [WORD_W-1:0] asm_ff;
   logic [1:0]        bytes_ff;
   logic [IDX_W-1:0]  wr_idx_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [WORD_W-1:0] out_word_ff;
   logic [POS_W-1:0]  out_pos_ff;
   logic              out_last_ff;
   logic [WORD_W-1:0] store_mem [FRAME_WORDS];
   logic [WORD_W-1:0] word_in;

   assign word_in = {rx_byte, asm_ff[WORD_W-1:BYTE_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff    <= '0;
         bytes_ff  <= '0;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         if (cmd.start_record) begin
            asm_ff   <= '0;
            bytes_ff <= '0;
         end else if (cmd.take_byte) begin
            asm_ff   <= word_in;
            bytes_ff <= bytes_ff + 2'd1;
         end
         if (cmd.clear_count) begin
            wr_idx_ff <= '0;
         end else if (cmd.store_word) begin
            wr_idx_ff <= wr_idx_ff + 1'b1;
         end
         if (cmd.drain_start) begin
            rd_idx_ff <= '0;
         end else if (cmd.drain_read) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   // value store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store_word) begin
         store_mem[wr_idx_ff] <= word_in;
      end
      if (cmd.drain_read) begin
         out_word_ff <= store_mem[rd_idx_ff];
         out_pos_ff  <= POS_W'(rd_idx_ff);
         out_last_ff <= (rd_idx_ff == LAST_IDX);
      end
   end

   always_comb begin
      sts.is_start   = (rx_byte == start_marker_ff);
      sts.is_end     = (rx_byte == end_marker_ff);
      sts.is_size    = (rx_byte == RECORD_SIZE);
      sts.last_byte  = (bytes_ff == 2'd3);
      sts.count_last = (wr_idx_ff == LAST_IDX);
      sts.out_last   = out_last_ff;
   end

   assign word_value    = out_word_ff;
   assign word_position = out_pos_ff;
   assign last_of_frame = out_last_ff;

endmodule

FILE: design/mfwr_controller.sv
// ---------------------------------------------------------------------------
// mfwr_controller
// frame parsing state machine and result drain sequencing
// ---------------------------------------------------------------------------
`include "marker_framed_word_receiver_defines.svh"

module mfwr_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mfwr_pkg::ctl_cmd_type cmd,
   input  mfwr_pkg::ctl_sts_type sts
);
   import mfwr_pkg::*;

   typedef enum logic [2:0] {
      S_HUNT,
      S_SIZE,
      S_PAYLOAD,
      S_END,
      S_READ,
      S_SHOW
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      take;

   assign req_ready = (state_ff != S_READ) && (state_ff != S_SHOW);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_HUNT:    cmd.clear_count  = take && sts.is_start;
         S_SIZE:    cmd.start_record = take && sts.is_size;
         S_PAYLOAD: begin
            cmd.take_byte  = take;
            cmd.store_word = take && sts.last_byte;
         end
         S_END:     cmd.drain_start  = take && sts.is_end;
         S_READ:    cmd.drain_read   = 1'b1;
         S_SHOW:    ;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_HUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_HUNT: begin
               if (take && sts.is_start) state_ff <= S_SIZE;
            end
            S_SIZE: begin
               if (take) state_ff <= sts.is_size ? S_PAYLOAD : S_HUNT;
            end
            S_PAYLOAD: begin
               if (take && sts.last_byte) state_ff <= sts.count_last ? S_END : S_SIZE;
            end
            S_END: begin
               if (take && sts.is_end) state_ff <= S_READ;
            end
            S_READ: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_SHOW;
            end
            S_SHOW: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= sts.out_last ? S_HUNT : S_READ;
               end
            end
            default: state_ff <= S_HUNT;
         endcase
      end
   end

   `MFWR_ASSERT_IMPLY(a_no_input_while_showing, rsp_valid_ff, !req_ready)
   `MFWR_ASSERT_NEXT(a_read_then_show, cmd.drain_read, rsp_valid_ff)
   `MFWR_ASSERT_NEXT(a_full_frame_to_end, cmd.store_word && sts.count_last, state_ff == S_END)

endmodule

FILE: design/marker_framed_word_receiver.sv
// ---------------------------------------------------------------------------
// marker_framed_word_receiver
// parses start marker, size-prefixed 32-bit records and end marker, then
// emits the stored words of a complete frame in order
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  req_chan  in         rx_byte
//  rsp_chan  out        word_value, word_position, last_of_frame
//  csr_*     in         start_marker (index 0), end_marker (index 1)
//
//  one received byte accepted per cycle while parsing
//  an end marker starts a drain of FRAME_WORDS words, each read through the
//  single store read port and then held until taken, no byte transfer during the drain
//  rsp stalls hold the current word and extend the drain
//  synchronous reset returns to hunting with markers 3 and 4
// ---------------------------------------------------------------------------
module marker_framed_word_receiver #(
   parameter int FRAME_WORDS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   mfwr_req_if.sink                         req_chan,
   mfwr_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [mfwr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfwr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mfwr_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   mfwr_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mfwr_datapath #(
      .FRAME_WORDS (FRAME_WORDS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rx_byte       (req_chan.rx_byte),
      .cmd           (cmd),
      .sts           (sts),
      .word_value    (rsp_chan.word_value),
      .word_position (rsp_chan.word_position),
      .last_of_frame (rsp_chan.last_of_frame)
   );

endmodule

FILE: bench/tb_marker_framed_word_receiver.sv
// ---------------------------------------------------------------------------
// tb_marker_framed_word_receiver
// drives received bytes through the frame parser with random gaps and
// result stalls, predicts every emitted word from its own parser state and
// compares each word transfer against the oldest predicted word
// ---------------------------------------------------------------------------
module tb_marker_framed_word_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   import mfwr_pkg::*;

   localparam int FRAME_WORDS = 10;

   typedef logic [BYTE_W-1:0] rx_byte_type;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SIZE,
      PH_PAYLOAD,
      PH_AWAIT_END
   } parse_phase_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [POS_W-1:0]         pos;
      logic                     last;
   } frame_word_type;

   logic clock = 1'b0;
   logic reset;

   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mfwr_req_if req_bus ();
   mfwr_rsp_if rsp_bus ();

   marker_framed_word_receiver #(
      .FRAME_WORDS (FRAME_WORDS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state as predicted
   rx_byte_type     start_marker_q;
   rx_byte_type     end_marker_q;
   parse_phase_type phase_q;
   int unsigned  nbytes_q;
   logic [WORD_W-1:0] word_q;
   int unsigned  count_q;
   logic [WORD_W-1:0] store_q [FRAME_WORDS];

   frame_word_type pending_words [$];
   frame_word_type got_word;
   frame_word_type want_word;

   int unsigned bytes_sent;
   int unsigned frames_emitted;
   int unsigned words_checked;
   int unsigned fail_count;
   int unsigned settings_tried;
   bit          idle_free;

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%t: %s", $realtime, msg);
   endtask

   function automatic void parse_byte(input rx_byte_type b);
      frame_word_type entry;
      case (phase_q)
         PH_HUNT: begin
            if (b == start_marker_q) begin
               count_q = 0;
               phase_q = PH_SIZE;
            end
         end
         PH_SIZE: begin
            if (b == RECORD_SIZE) begin
               nbytes_q = 0;
               word_q   = '0;
               phase_q  = PH_PAYLOAD;
            end else begin
               phase_q = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            word_q = word_q | (WORD_W'(b) << (8 * (nbytes_q % 4)));
            nbytes_q++;
            if (nbytes_q >= 4) begin
               store_q[count_q] = word_q;
               count_q++;
               phase_q = (count_q >= FRAME_WORDS) ? PH_AWAIT_END : PH_SIZE;
            end
         end
         default: begin
            if (b == end_marker_q) begin
               if (count_q == FRAME_WORDS) begin
                  for (int i = 0; i < FRAME_WORDS; i++) begin
                     entry.value = store_q[i];
                     entry.pos   = POS_W'(i);
                     entry.last  = (i == FRAME_WORDS - 1);
                     pending_words.push_back(entry);
                  end
                  frames_emitted++;
               end
               phase_q = PH_HUNT;
            end
         end
      endcase
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (idle_free || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input rx_byte_type b);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      parse_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_drained(input int unsigned settle);
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_marker(input logic [CSR_INDEX_W-1:0] idx, input rx_byte_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_START_MARKER)
         start_marker_q = value;
      else
         end_marker_q = value;
      @(posedge clock);
   endtask

   task automatic send_record();
      logic [WORD_W-1:0] w;
      int unsigned r;
      r = $urandom_range(0, 99);
      case (r % 5)
         0: w = 32'h8000_0000;
         1: w = 32'h7fff_ffff;
         2: w = 32'hffff_ffff;
         3: w = 32'h0000_0000;
         default: w = $urandom;
      endcase
      if (r >= 20)
         w = $urandom;
      send_byte(RECORD_SIZE);
      for (int k = 0; k < 4; k++) begin
         r = $urandom_range(0, 99);
         if (r < 8)
            send_byte(start_marker_q);
         else if (r < 16)
            send_byte(end_marker_q);
         else if (r < 20)
            send_byte(RECORD_SIZE);
         else
            send_byte(w[8*k +: 8]);
      end
   endtask

   task automatic send_random_sequence();
      int unsigned r;
      rx_byte_type b;
      r = $urandom_range(0, 99);
      idle_free = ($urandom_range(0, 3) == 0);
      if (r < 65) begin
         send_byte(start_marker_q);
         repeat (FRAME_WORDS) send_record();
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               b = rx_byte_type'($urandom);
               if (b == end_marker_q)
                  b = ~b;
               send_byte(b);
            end
         end
         send_byte(end_marker_q);
      end else if (r < 85) begin
         // frame cut short by a wrong size byte
         send_byte(start_marker_q);
         repeat ($urandom_range(0, FRAME_WORDS - 1)) send_record();
         b = ($urandom_range(0, 2) == 0) ? start_marker_q : rx_byte_type'($urandom);
         if (b == RECORD_SIZE)
            b = ~b;
         send_byte(b);
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(rx_byte_type'($urandom));
      end
   endtask

   task automatic test_hunt_ignores_noise();
      idle_free = 1'b0;
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(END_MARKER_RESET);
   endtask

   task automatic test_bad_size_byte();
      // marker value as size byte returns to hunting without a restart
      send_byte(START_MARKER_RESET);
      send_byte(START_MARKER_RESET);
      send_byte(RECORD_SIZE);
      send_byte(START_MARKER_RESET);
      send_byte(8'h05);
   endtask

   task automatic test_payload_takes_any_byte();
      send_byte(START_MARKER_RESET);
      send_byte(RECORD_SIZE);
      send_byte(START_MARKER_RESET);
      send_byte(END_MARKER_RESET);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(START_MARKER_RESET);
      send_byte(RECORD_SIZE);
      repeat (4) send_byte(8'hff);
      send_byte(8'h00);
   endtask

   task automatic test_marker_setting(input rx_byte_type start_value,
                                      input rx_byte_type end_value,
                                      input int unsigned target);
      int unsigned bytes_at_start;
      int unsigned frames_at_start;
      wait_drained(8);
      write_marker(CSR_START_MARKER, start_value);
      write_marker(CSR_END_MARKER, end_value);
      settings_tried++;
      bytes_at_start  = bytes_sent;
      frames_at_start = frames_emitted;
      while (bytes_sent - bytes_at_start < target || frames_emitted == frames_at_start)
         send_random_sequence();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got_word.value = rsp_bus.word_value;
         got_word.pos   = rsp_bus.word_position;
         got_word.last  = rsp_bus.last_of_frame;
         if (pending_words.size() == 0) begin
            note_failure($sformatf("unexpected word transfer: value %0d pos %0d last %0b",
                                   got_word.value, got_word.pos, got_word.last));
         end else begin
            want_word = pending_words.pop_front();
            words_checked++;
            if (got_word.value !== want_word.value || got_word.pos !== want_word.pos ||
                got_word.last !== want_word.last)
               note_failure($sformatf(
                  "word mismatch: expected value %0d pos %0d last %0b, got %0d pos %0d last %0b",
                  want_word.value, want_word.pos, want_word.last,
                  got_word.value, got_word.pos, got_word.last));
         end
      end
   end

   initial begin : rsp_stalls
      int unsigned hold;
      int unsigned calm;
      int unsigned r;
      hold = 0;
      calm = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else if (calm != 0) begin
            rsp_bus.ready <= 1'b1;
            calm--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               calm = $urandom_range(50, 200);
               rsp_bus.ready <= 1'b1;
            end else if (r < 70) begin
               rsp_bus.ready <= 1'b1;
            end else if (r < 95) begin
               rsp_bus.ready <= 1'b0;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_bus.ready <= 1'b0;
               hold = $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d words still expected", pending_words.size());
      $display("tb_marker_framed_word_receiver: errors");
      $finish;
   end

   initial begin
      start_marker_q = START_MARKER_RESET;
      end_marker_q   = END_MARKER_RESET;
      phase_q        = PH_HUNT;
      nbytes_q       = 0;
      word_q         = '0;
      count_q        = 0;
      bytes_sent     = 0;
      frames_emitted = 0;
      words_checked  = 0;
      fail_count     = 0;
      settings_tried = 0;
      idle_free      = 1'b0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_hunt_ignores_noise();
      test_bad_size_byte();
      test_payload_takes_any_byte();
      test_marker_setting(START_MARKER_RESET, END_MARKER_RESET, 50);
      test_marker_setting(8'hff, 8'h00, 50);
      test_marker_setting(8'h00, 8'hff, 50);
      test_marker_setting(RECORD_SIZE, RECORD_SIZE, 50);

      wait_drained(40);
      $display("%0d bytes transferred under %0d marker settings, %0d frames completed",
               bytes_sent, settings_tried, frames_emitted);
      $display("%0d words compared, %0d failures", words_checked, fail_count);
      if (fail_count == 0)
         $display("tb_marker_framed_word_receiver: clean");
      else
         $display("tb_marker_framed_word_receiver: errors");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/mfwr_pkg.sv
design/mfwr_channels.sv
design/mfwr_datapath.sv
design/mfwr_controller.sv
design/marker_framed_word_receiver.sv
bench/tb_marker_framed_word_receiver.sv
